// ===== rtl/gwpc_pkg.sv =====
// shared types, constants and helper functions for the grid word pattern counter
// no dependencies; used by gwpc_line_buf and grid_word_pattern_counter_core

package gwpc_pkg;

    // fixed field widths
    localparam int CH_W     = 8;
    localparam int CFG_W    = 9;
    localparam int MATCH_W  = 3;
    localparam int TOTAL_W  = 24;
    localparam int SLOTS    = 3;
    localparam int WORD_W   = SLOTS * CH_W;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 32;

    // row width after reset
    localparam logic [CFG_W-1:0] RESET_ROW_WIDTH = 9'd140;

    // pattern letters
    localparam logic [CH_W-1:0] CH_X = 8'h58;
    localparam logic [CH_W-1:0] CH_M = 8'h4D;
    localparam logic [CH_W-1:0] CH_A = 8'h41;
    localparam logic [CH_W-1:0] CH_S = 8'h53;

    // line buffer slot codes
    localparam logic [1:0] SLOT_0 = 2'd0;
    localparam logic [1:0] SLOT_1 = 2'd1;
    localparam logic [1:0] SLOT_2 = 2'd2;

    typedef logic [1:0]        slot_t;
    typedef logic [CH_W-1:0]   char_t;
    typedef logic [WORD_W-1:0] word_t;

    // per-request control from the core to the line buffer
    typedef struct packed {
        logic step;
        logic row_end;
    } lb_ctrl_t;

    // four characters read XMAS or SAMX
    function automatic logic word_hit(input char_t a, input char_t b,
                                      input char_t c, input char_t d);
        logic fwd;
        logic rev;
        fwd = (a == CH_X) && (b == CH_M) && (c == CH_A) && (d == CH_S);
        rev = (a == CH_S) && (b == CH_A) && (c == CH_M) && (d == CH_X);
        return fwd || rev;
    endfunction

    // next slot, modulo three
    function automatic slot_t slot_inc(input slot_t s);
        slot_t r;
        case (s)
            SLOT_0:  r = SLOT_1;
            SLOT_1:  r = SLOT_2;
            default: r = SLOT_0;
        endcase
        return r;
    endfunction

    // pick one slot's character out of a column word
    function automatic char_t lane_get(input word_t w, input slot_t s);
        char_t r;
        case (s)
            SLOT_0:  r = w[CH_W-1:0];
            SLOT_1:  r = w[2*CH_W-1:CH_W];
            default: r = w[3*CH_W-1:2*CH_W];
        endcase
        return r;
    endfunction

    // replace one slot's character in a column word
    function automatic word_t lane_put(input word_t w, input slot_t s, input char_t c);
        word_t r;
        r = w;
        case (s)
            SLOT_0:  r[CH_W-1:0]        = c;
            SLOT_1:  r[2*CH_W-1:CH_W]   = c;
            default: r[3*CH_W-1:2*CH_W] = c;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/gwpc_line_buf.sv =====
// line buffer: column-packed memory of the three previous rows, head-column flops,
// row-end write queue with read forwarding, and the 7-column read window
// depends on gwpc_pkg

module gwpc_line_buf #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  gwpc_pkg::lb_ctrl_t                              ctrl,
    input  logic [$clog2(MAX_WIDTH)-1:0]                    col,
    input  gwpc_pkg::slot_t                                 slot,
    input  logic [2:0][gwpc_pkg::CH_W-1:0]                  rc,
    input  gwpc_pkg::char_t                                 ch,
    output logic [6:0][gwpc_pkg::WORD_W-1:0]                win
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int XW   = ((WW > gwpc_pkg::CFG_W) ? WW : gwpc_pkg::CFG_W) + 1;
    localparam logic [XW-1:0] MAX_X = XW'(MAX_WIDTH);
    localparam int HEAD = 4;

    // column memory, one byte lane per slot
    gwpc_pkg::word_t mem [0:MAX_WIDTH-1];
    gwpc_pkg::word_t rd_data_reg;

    // head columns 0..3 live in flops
    gwpc_pkg::word_t [HEAD-1:0] head_reg, head_next;

    // window of columns c-3..c+3 from the last request
    logic [6:0][gwpc_pkg::WORD_W-1:0] win_reg;

    // row-end write queue
    logic [2:0]                           pend_valid_reg, pend_valid_next;
    logic [2:0][CW-1:0]                   pend_col_reg, pend_col_next;
    logic [2:0][gwpc_pkg::CH_W-1:0]       pend_char_reg, pend_char_next;
    gwpc_pkg::slot_t                      pend_slot_reg, pend_slot_next;

    // forwarded byte for the prefetched column
    logic                                 fwd_valid_reg;
    gwpc_pkg::char_t                      fwd_char_reg;
    gwpc_pkg::slot_t                      fwd_slot_reg;

    logic [XW-1:0]                        cx;
    logic [XW-1:0]                        rd_addr_x;
    logic [XW-1:0]                        norm_col_x;
    logic                                 rd_en;
    logic [CW-1:0]                        rd_addr;
    logic                                 norm_en;
    logic                                 norm_mem;
    logic [2:0]                           new_v;
    logic [2:0][gwpc_pkg::CH_W-1:0]       new_ch;
    logic [2:0]                           match;
    logic                                 drain_en;
    logic [1:0]                           drain_idx;
    logic [2:0]                           drain_oh;
    logic                                 mem_we;
    logic [CW-1:0]                        mem_wa;
    gwpc_pkg::slot_t                      mem_wslot;
    gwpc_pkg::char_t                      mem_wd;
    gwpc_pkg::word_t                      rd_word;
    gwpc_pkg::char_t                      fwd_char_sel;

    // address arithmetic around the current column
    always_comb begin
        cx         = XW'(col);
        rd_addr_x  = cx + XW'(4);
        rd_en      = ctrl.step && (rd_addr_x < MAX_X);
        rd_addr    = rd_addr_x[CW-1:0];
        norm_col_x = cx - XW'(3);
        norm_en    = ctrl.step && (cx >= XW'(3));
        norm_mem   = norm_en && (norm_col_x >= XW'(HEAD));
        new_ch[0]  = rc[1];
        new_ch[1]  = rc[0];
        new_ch[2]  = ch;
        for (int j = 0; j < 3; j++) begin
            new_v[j] = ctrl.step && ctrl.row_end && ((cx + XW'(j)) >= XW'(6));
        end
    end

    // queue drain, lowest entry first, when the normal write leaves the port free
    always_comb begin
        drain_idx = 2'd0;
        drain_oh  = 3'b000;
        if (pend_valid_reg[0]) begin
            drain_idx = 2'd0;
            drain_oh  = 3'b001;
        end else if (pend_valid_reg[1]) begin
            drain_idx = 2'd1;
            drain_oh  = 3'b010;
        end else if (pend_valid_reg[2]) begin
            drain_idx = 2'd2;
            drain_oh  = 3'b100;
        end
        drain_en = !norm_mem && (pend_valid_reg != 3'b000);
        if (!drain_en) begin
            drain_oh = 3'b000;
        end
    end

    // single write port
    always_comb begin
        mem_we    = norm_mem || drain_en;
        mem_wa    = norm_mem ? norm_col_x[CW-1:0] : pend_col_reg[drain_idx];
        mem_wslot = norm_mem ? slot : pend_slot_reg;
        mem_wd    = norm_mem ? rc[2] : pend_char_reg[drain_idx];
    end

    // queue next state
    always_comb begin
        pend_valid_next = (pend_valid_reg & ~drain_oh) | new_v;
        pend_col_next   = pend_col_reg;
        pend_char_next  = pend_char_reg;
        pend_slot_next  = (new_v != 3'b000) ? slot : pend_slot_reg;
        for (int j = 0; j < 3; j++) begin
            if (new_v[j]) begin
                pend_col_next[j]  = CW'(cx + XW'(j) - XW'(2));
                pend_char_next[j] = new_ch[j];
            end
        end
    end

    // forwarding from queued writes into the prefetch
    always_comb begin
        fwd_char_sel = pend_char_reg[0];
        for (int j = 0; j < 3; j++) begin
            match[j] = pend_valid_reg[j] && (pend_col_reg[j] == rd_addr);
        end
        if (match[1]) begin
            fwd_char_sel = pend_char_reg[1];
        end else if (match[2]) begin
            fwd_char_sel = pend_char_reg[2];
        end
    end

    // head column updates
    always_comb begin
        logic [XW-1:0] hc;
        head_next = head_reg;
        if (norm_en && (norm_col_x < XW'(HEAD))) begin
            head_next[norm_col_x[1:0]] = gwpc_pkg::lane_put(head_next[norm_col_x[1:0]],
                                                            slot, rc[2]);
        end
        for (int j = 0; j < 3; j++) begin
            hc = cx + XW'(j);
            if (ctrl.step && ctrl.row_end && (hc >= XW'(2)) && (hc < XW'(6))) begin
                head_next[2'(hc - XW'(2))] =
                    gwpc_pkg::lane_put(head_next[2'(hc - XW'(2))], slot, new_ch[j]);
            end
        end
    end

    // window for the current column
    always_comb begin
        rd_word = rd_data_reg;
        if (fwd_valid_reg) begin
            rd_word = gwpc_pkg::lane_put(rd_data_reg, fwd_slot_reg, fwd_char_reg);
        end
        if (cx == XW'(0)) begin
            win[0] = '0;
            win[1] = '0;
            win[2] = '0;
            win[3] = head_reg[0];
            win[4] = head_reg[1];
            win[5] = head_reg[2];
            win[6] = head_reg[3];
        end else begin
            for (int j = 0; j < 6; j++) begin
                win[j] = win_reg[j+1];
            end
            win[6] = rd_word;
        end
    end

    // memory ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa][8*mem_wslot +: 8] <= mem_wd;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        head_reg       <= head_next;
        pend_col_reg   <= pend_col_next;
        pend_char_reg  <= pend_char_next;
        pend_slot_reg  <= pend_slot_next;
        if (ctrl.step) begin
            win_reg      <= win;
            fwd_char_reg <= fwd_char_sel;
            fwd_slot_reg <= pend_slot_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 3'b000;
            fwd_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            if (ctrl.step) begin
                fwd_valid_reg <= rd_en && (match != 3'b000);
            end
        end
    end

    // queue is always empty once a row is far enough along to write memory itself
    assert property (@(posedge aclk) disable iff (!aresetn)
        norm_mem |-> (pend_valid_reg == 3'b000))
        else $error("line buffer write queue busy during normal write");

    // a row end never stacks on queued writes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (new_v != 3'b000) |-> (pend_valid_reg == 3'b000))
        else $error("row end queued writes overlap earlier ones");

    // every queued row-end write drains from the queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (new_v != 3'b000) |=> ##3 (pend_valid_reg == 3'b000))
        else $error("row end write queue did not drain");

    // memory byte lane always a real slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (mem_wslot != 2'd3))
        else $error("memory write to undefined slot");

endmodule

// ===== rtl/grid_word_pattern_counter_core.sv =====
// counts XMAS / SAMX windows in four directions over a raster-order character grid
// results: each result is registered in the output register, or in the skid stage while the output is held
// throughput: one character per cycle while the skid stage is empty, set by the one-read, one-write line memory
// reset: position, rows, slot, recent characters and total clear; row width goes to 140
// line memory is not cleared; row entries are written before any read that counts
// depends on gwpc_pkg and gwpc_line_buf

module grid_word_pattern_counter_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int COUNT_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // [7:0] ch
    input  logic [gwpc_pkg::S_DATA_W-1:0]       s_tdata,
    // [0] frame_start
    input  logic [0:0]                          s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [2:0] matches_here, [26:3] total, [31:27] zero
    output logic [gwpc_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gwpc_pkg::CFG_W-1:0]          cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = ((WW > gwpc_pkg::CFG_W) ? WW : gwpc_pkg::CFG_W) + 1;
    localparam logic [XW-1:0] MAX_X = XW'(MAX_WIDTH);
    localparam int PAD_W = gwpc_pkg::M_DATA_W - gwpc_pkg::MATCH_W - gwpc_pkg::TOTAL_W;

    // state
    logic [gwpc_pkg::CFG_W-1:0]           width_reg;
    logic [CW-1:0]                        col_reg, col_next;
    logic [1:0]                           rows_reg, rows_next;
    gwpc_pkg::slot_t                      slot_reg, slot_next;
    logic [2:0][gwpc_pkg::CH_W-1:0]       rc_reg, rc_next;
    logic [COUNT_BITS-1:0]                total_reg, total_next;

    // output register and skid stage
    logic                                 out_valid_reg;
    logic [gwpc_pkg::M_DATA_W-1:0]        out_data_reg;
    logic                                 skid_valid_reg;
    logic [gwpc_pkg::M_DATA_W-1:0]        skid_data_reg;

    logic                                 s_acc;
    logic                                 fs;
    gwpc_pkg::char_t                      ch;
    logic [CW-1:0]                        c_eff;
    logic [1:0]                           rows_eff;
    gwpc_pkg::slot_t                      slot_eff;
    logic [2:0][gwpc_pkg::CH_W-1:0]       rc_eff;
    logic [COUNT_BITS-1:0]                tot_eff;
    logic [XW-1:0]                        cfg_x;
    logic [XW-1:0]                        w_x;
    logic [XW-1:0]                        c_x;
    logic                                 row_end;
    logic                                 anti_ok;
    gwpc_pkg::slot_t                      s3, s2, s1;
    logic [6:0][gwpc_pkg::WORD_W-1:0]     win;
    gwpc_pkg::lb_ctrl_t                   lb_ctrl;
    logic                                 h_hor, h_ver, h_dia, h_ant;
    logic [gwpc_pkg::MATCH_W-1:0]         hits;
    logic [COUNT_BITS:0]                  sum_x;
    logic [gwpc_pkg::TOTAL_W+COUNT_BITS-1:0] total_ext;
    logic [gwpc_pkg::M_DATA_W-1:0]        res_data;

    // input unpacking
    assign s_acc     = s_tvalid && s_tready;
    assign fs        = s_tuser[0];
    assign ch        = s_tdata[gwpc_pkg::CH_W-1:0];
    assign cfg_ready = 1'b1;

    // frame start clears the state seen by this character
    always_comb begin
        c_eff    = fs ? '0 : col_reg;
        rows_eff = fs ? 2'd0 : rows_reg;
        slot_eff = fs ? gwpc_pkg::SLOT_0 : slot_reg;
        rc_eff   = fs ? '0 : rc_reg;
        tot_eff  = fs ? '0 : total_reg;
    end

    // effective row width and position tests
    always_comb begin
        cfg_x   = XW'(width_reg);
        w_x     = ((cfg_x == XW'(0)) || (cfg_x > MAX_X)) ? MAX_X : cfg_x;
        c_x     = XW'(c_eff);
        row_end = (c_x + XW'(1)) >= w_x;
        anti_ok = (c_x + XW'(3)) < w_x;
        s3      = slot_eff;
        s2      = gwpc_pkg::slot_inc(s3);
        s1      = gwpc_pkg::slot_inc(s2);
    end

    assign lb_ctrl.step    = s_acc;
    assign lb_ctrl.row_end = row_end;

    gwpc_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (lb_ctrl),
        .col     (c_eff),
        .slot    (slot_eff),
        .rc      (rc_eff),
        .ch      (ch),
        .win     (win)
    );

    // window compares in the four directions
    always_comb begin
        h_hor = (c_x >= XW'(3)) &&
                gwpc_pkg::word_hit(rc_eff[2], rc_eff[1], rc_eff[0], ch);
        h_ver = (rows_eff == 2'd3) &&
                gwpc_pkg::word_hit(gwpc_pkg::lane_get(win[3], s3),
                                   gwpc_pkg::lane_get(win[3], s2),
                                   gwpc_pkg::lane_get(win[3], s1), ch);
        h_dia = (rows_eff == 2'd3) && (c_x >= XW'(3)) &&
                gwpc_pkg::word_hit(gwpc_pkg::lane_get(win[0], s3),
                                   gwpc_pkg::lane_get(win[1], s2),
                                   gwpc_pkg::lane_get(win[2], s1), ch);
        h_ant = (rows_eff == 2'd3) && anti_ok &&
                gwpc_pkg::word_hit(gwpc_pkg::lane_get(win[6], s3),
                                   gwpc_pkg::lane_get(win[5], s2),
                                   gwpc_pkg::lane_get(win[4], s1), ch);
        hits  = gwpc_pkg::MATCH_W'(h_hor) + gwpc_pkg::MATCH_W'(h_ver) +
                gwpc_pkg::MATCH_W'(h_dia) + gwpc_pkg::MATCH_W'(h_ant);
    end

    // saturating total
    always_comb begin
        sum_x      = {1'b0, tot_eff} + (COUNT_BITS+1)'(hits);
        total_next = sum_x[COUNT_BITS] ? '1 : sum_x[COUNT_BITS-1:0];
        total_ext  = {gwpc_pkg::TOTAL_W'(0), total_next};
        res_data   = {PAD_W'(0), total_ext[gwpc_pkg::TOTAL_W-1:0], hits};
    end

    // position, slot and recent characters
    always_comb begin
        if (row_end) begin
            col_next  = '0;
            rows_next = (rows_eff == 2'd3) ? 2'd3 : 2'(rows_eff + 2'd1);
            slot_next = gwpc_pkg::slot_inc(slot_eff);
            rc_next   = '0;
        end else begin
            col_next  = CW'(c_x + XW'(1));
            rows_next = rows_eff;
            slot_next = slot_eff;
            rc_next   = {rc_eff[1:0], ch};
        end
    end

    // grid state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= gwpc_pkg::RESET_ROW_WIDTH;
            col_reg   <= '0;
            rows_reg  <= 2'd0;
            slot_reg  <= gwpc_pkg::SLOT_0;
            rc_reg    <= '0;
            total_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                width_reg <= cfg_data;
            end
            if (s_acc) begin
                col_reg   <= col_next;
                rows_reg  <= rows_next;
                slot_reg  <= slot_next;
                rc_reg    <= rc_next;
                total_reg <= total_next;
            end
        end
    end

    // output register with skid stage
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (m_tready || !out_valid_reg) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= s_acc;
                end
            end else if (s_acc) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_data;
        end else if (s_acc) begin
            skid_data_reg <= res_data;
        end
    end

    // skid stage only fills behind a held output
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full with output register empty");

    // write slot stays one of the three line buffers
    assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg != 2'd3)
        else $error("line buffer slot out of range");

    // total only grows within a grid
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !fs) |=> (total_reg >= $past(total_reg)))
        else $error("running total decreased inside a grid");

    // a row end always returns the column to zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && row_end) |=> (col_reg == '0))
        else $error("column not cleared at row end");

endmodule
